>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and codes for the LRU key-value cache: operation codes,
// controller states and the command/status structs between controller
// and datapath.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  localparam int unsigned CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } lkv_state_t;

  typedef struct packed {
    logic load;    // capture the accepted request
    logic lookup;  // parallel key compare, victim and free slot search
    logic commit;  // rank update, writeback and result load
  } lkv_cmd_t;

  typedef struct packed {
    logic out_free;  // result register empty or being drained
  } lkv_status_t;

endpackage

>>> rtl/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Request sequencer: accept, lookup, then update and result load. A new
// request is taken in the update cycle when the result register is free.
// ----------------------------------------------------------------------------
module lkv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  lkv_pkg::lkv_status_t status,
  output lkv_pkg::lkv_cmd_t    cmd
);
  import lkv_pkg::*;

  lkv_state_t state;
  lkv_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status.out_free) state_next = s_tvalid ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      ST_UPDATE: begin
        s_tready   = status.out_free;
        cmd.commit = status.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
    cmd.load = s_tvalid && s_tready;
  end

  // a finished update always moves on
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == ST_IDLE || state == ST_LOOKUP))
    else $error("update did not complete after commit");

endmodule

>>> rtl/lkv_datapath.sv
// ----------------------------------------------------------------------------
// lkv_datapath
// Key CAM, valid bits, recency ranks, occupancy, capacity register, value
// RAM and result register of the LRU key-value cache.
// ----------------------------------------------------------------------------
module lkv_datapath #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lkv_pkg::lkv_cmd_t          cmd,
  output lkv_pkg::lkv_status_t       status,
  input  logic                       cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                       in_func,
  input  logic [KEY_WIDTH-1:0]       in_key,
  input  logic [VALUE_WIDTH-1:0]     in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [VALUE_WIDTH-1:0]     out_value
);
  import lkv_pkg::*;

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // request registers
  logic                   req_put;
  logic [KEY_WIDTH-1:0]   req_key;
  logic [VALUE_WIDTH-1:0] req_value;

  // entry state
  logic [MAX_ENTRIES-1:0] valid;
  logic [KEY_WIDTH-1:0]   entry_key [MAX_ENTRIES];
  logic [IDX_W-1:0]       rank [MAX_ENTRIES];
  logic [CNT_W-1:0]       occupancy;
  logic [CAP_W-1:0]       capacity;

  // lookup results
  logic                   hit;
  logic                   evict;
  logic [IDX_W-1:0]       slot;
  logic [IDX_W-1:0]       touch_rank;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // lookup logic
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] victim;
  logic [MAX_ENTRIES-1:0] free_oh;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       victim_idx;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       hit_rank;
  logic [CNT_W-1:0]       occ_m1;
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       cap_eff;
  logic                   lk_hit;
  logic                   lk_full;

  always_comb begin
    occ_m1  = occupancy - CNT_W'(1);
    cap_ext = CMP_W'(capacity);
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
    lk_full = CMP_W'(occupancy) >= cap_eff;
    free_oh = ~valid & (valid + MAX_ENTRIES'(1));
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    hit_rank   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i]  = valid[i] && (entry_key[i] == req_key);
      victim[i] = valid[i] && (rank[i] == occ_m1[IDX_W-1:0]);
      if (match[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | rank[i];
      end
      if (victim[i]) victim_idx = victim_idx | IDX_W'(i);
      if (free_oh[i]) free_idx = free_idx | IDX_W'(i);
    end
    lk_hit = |match;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_put   <= (in_func == FUNC_PUT);
      req_key   <= in_key;
      req_value <= in_value;
    end
    if (cmd.lookup) begin
      hit        <= lk_hit;
      evict      <= lk_full && !lk_hit;
      touch_rank <= hit_rank;
      if (lk_hit) begin
        slot <= hit_idx;
      end else if (lk_full) begin
        slot <= victim_idx;
      end else begin
        slot <= free_idx;
      end
    end
    if (cmd.commit && req_put && !hit) begin
      entry_key[slot] <= req_key;
    end
    if (cmd.commit) begin
      out_hit   <= hit;
      out_value <= (!req_put && hit) ? ram_rdata : '0;
    end
  end

  logic update_ranks;
  assign update_ranks = cmd.commit && (hit || req_put);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occupancy <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) capacity <= cfg_wr_data;
      if (update_ranks) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (IDX_W'(i) == slot) begin
            rank[i] <= '0;
          end else if (valid[i] && (!hit || rank[i] < touch_rank)) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end
      end
      if (cmd.commit && req_put && !hit) begin
        valid[slot] <= 1'b1;
        if (!evict) occupancy <= occupancy + CNT_W'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid || out_ready;

  lkv_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (cmd.commit && req_put),
    .waddr (slot),
    .wdata (req_value),
    .re    (cmd.lookup),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(occupancy))
    else $error("occupancy out of step with valid bits");

  assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |-> $onehot0(match))
    else $error("duplicate key in cache");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.lookup && lk_full && !lk_hit) |-> $onehot(victim))
    else $error("no unique LRU victim");

  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not loaded after commit");

endmodule

>>> rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// Gets return the stored value on a hit; puts update or insert, evicting
// the least recent entry once the configured capacity is reached.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser: func; tdata: lookup_key, write_value
//   m_*      out  m_tvalid/m_tready  tuser: hit;  tdata: read_value
//   cfg_*    in   cfg_wr_en          cfg_wr_data: capacity
//
// Each request passes a parallel key compare step, then a rank update and
// writeback step that also loads the result register. A new request is
// accepted in the update step of the previous one when the result register
// is free.
// Reset clears valid bits, ranks and occupancy; no sweep.
// With m_tready low the result holds and the next request stalls in update.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned S_DATA_W   = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned M_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [S_DATA_W-1:0]       s_tdata,   // lookup_key, write_value
  input  logic                      s_tuser,   // func
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [M_DATA_W-1:0]       m_tdata,   // read_value
  output logic                      m_tuser,   // hit
  input  logic                      cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data
);
  import lkv_pkg::*;

  lkv_cmd_t               cmd;
  lkv_status_t            status;
  logic [VALUE_WIDTH-1:0] read_value;

  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lkv_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_func     (s_tuser),
    .in_key      (s_tdata[KEY_WIDTH-1:0]),
    .in_value    (s_tdata[KEY_WIDTH +: VALUE_WIDTH]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_hit     (m_tuser),
    .out_value   (read_value)
  );

  assign m_tdata = M_DATA_W'(read_value);

endmodule

>>> verif/tb_lru_key_value_cache_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit
// Self-checking bench for the LRU key-value cache. A queue-fed driver offers
// get/put requests, and a scoreboard model predicts hit and read value at each
// accepted request. A monitor then checks every result in order. Capacity is
// rewritten between phases, including zero, saturating and shrinking values.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;
  import lkv_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int LONG_HOLD   = 400;
  localparam int WDOG_LIMIT  = 3000;
  localparam int POOL_SIZE   = 24;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 118;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [31:0] value;
  } cache_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
  } cache_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;   // lookup_key, write_value
  logic                 s_tuser = 1'b0; // func
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;        // read_value
  logic                 m_tuser;        // hit
  logic                 cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]     cfg_wr_data = '0;

  cache_req_t    pending_reqs[$];
  cache_result_t lookup_results_q[$];

  // scoreboard copy of the cache
  logic             ent_valid [NUM_SLOTS];
  logic [31:0]      ent_key   [NUM_SLOTS];
  logic [31:0]      ent_value [NUM_SLOTS];
  int               ent_rank  [NUM_SLOTS];
  int               occupancy;
  logic [CAP_W-1:0] capacity;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_send;
  int  hold_trigger;
  int  hold_seen;
  int  hold_left;
  int  wdog_cnt;
  int  errors;
  logic [31:0] key_pool [POOL_SIZE];

  lru_key_value_cache_unit dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void promote(int s);
    int i;
    int r;
    r = ent_rank[s];
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (ent_valid[i] && ent_rank[i] < r) ent_rank[i]++;
    end
    ent_rank[s] = 0;
  endfunction

  function automatic cache_result_t cache_lookup(cache_req_t r);
    cache_result_t res;
    int i;
    int slot;
    int victim;
    int cap;
    bit found;
    bit any;
    res.hit = 1'b0;
    res.read_value = '0;
    slot = 0;
    found = 0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (!found && ent_valid[i] && ent_key[i] == r.key) begin
        slot = i;
        found = 1;
      end
    end
    res.hit = found;
    if (r.func == FUNC_GET) begin
      if (found) begin
        res.read_value = ent_value[slot];
        promote(slot);
      end
      return res;
    end
    if (found) begin
      ent_value[slot] = r.value;
      promote(slot);
      return res;
    end
    cap = (capacity == 0) ? 1 : ((capacity > NUM_SLOTS) ? NUM_SLOTS : int'(capacity));
    if (occupancy >= cap) begin
      any = 0;
      victim = 0;
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (ent_valid[i] && (!any || ent_rank[i] > ent_rank[victim])) begin
          victim = i;
          any = 1;
        end
      end
      if (any) begin
        ent_valid[victim] = 1'b0;
        ent_rank[victim] = 0;
        if (occupancy > 0) occupancy--;
      end
    end
    found = 0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (!found && !ent_valid[i]) begin
        slot = i;
        found = 1;
      end
    end
    if (!found) return res;
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (ent_valid[i]) ent_rank[i]++;
    end
    ent_valid[slot] = 1'b1;
    ent_key[slot] = r.key;
    ent_value[slot] = r.value;
    ent_rank[slot] = 0;
    occupancy++;
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        lookup_results_q.push_back(cache_lookup({s_tuser, s_tdata[31:0], s_tdata[63:32]}));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tuser  <= pending_reqs[0].func;
          s_tdata  <= {pending_reqs[0].value, pending_reqs[0].key};
          void'(pending_reqs.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cache_result_t exp_res;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (lookup_results_q.size() == 0) begin
          $error("result with no request pending: hit %0d read_value %h", m_tuser, m_tdata);
          errors++;
        end else begin
          exp_res = lookup_results_q.pop_front();
          if (m_tuser !== exp_res.hit) begin
            $error("hit mismatch: expected %0d actual %0d", exp_res.hit, m_tuser);
            errors++;
          end
          if (m_tdata !== exp_res.read_value) begin
            $error("read_value mismatch: expected %h actual %h", exp_res.read_value, m_tdata);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_seen != hold_trigger) begin
        hold_seen <= hold_trigger;
        hold_left <= LONG_HOLD;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      wdog_cnt <= 0;
    end else if (wdog_cnt >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      wdog_cnt <= wdog_cnt + 1;
    end
  end

  task automatic send(input logic func, input logic [31:0] key, input logic [31:0] value);
    cache_req_t r;
    r.func = func;
    r.key = key;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || s_tvalid || lookup_results_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity = v;
  endtask

  task automatic send_random(input int n, input int span);
    cache_req_t r;
    int k;
    for (k = 0; k < n; k++) begin
      r.func = $urandom_range(1) ? FUNC_PUT : FUNC_GET;
      if ($urandom_range(99) < 85) r.key = key_pool[$urandom_range(span - 1)];
      else r.key = $urandom;
      r.value = $urandom;
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    int i;
    int p;
    int span;
    int cap_eff;
    logic [CAP_W-1:0] caps [RAND_PHASES];
    caps = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd8, 5'd2, 5'd17};
    for (i = 0; i < NUM_SLOTS; i++) begin
      ent_valid[i] = 1'b0;
      ent_key[i] = '0;
      ent_value[i] = '0;
      ent_rank[i] = 0;
    end
    occupancy = 0;
    capacity = CAP_RESET;
    errors = 0;
    hold_send = 0;
    hold_trigger = 0;
    hold_seen = 0;
    hold_left = 0;
    wdog_cnt = 0;
    send_idle_pct = 10;
    recv_stall_pct = 10;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty miss, extremes, update, hits
    send(FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
    send(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send(FUNC_GET, 32'h8000_0000, 32'h5555_5555);
    send(FUNC_PUT, 32'h8000_0000, 32'h1234_5678);
    send(FUNC_GET, 32'h8000_0000, 32'h0);
    send(FUNC_GET, 32'h0000_0001, 32'h0);
    send(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    drain();
    // shrink below occupancy
    set_capacity(5'd2);
    send(FUNC_PUT, 32'h0000_0011, 32'hAAAA_AAAA);
    send(FUNC_PUT, 32'h0000_0022, 32'h5555_5555);
    send(FUNC_GET, 32'h7FFF_FFFF, 32'h0);
    send(FUNC_GET, 32'h0000_0000, 32'h0);
    send(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    send(FUNC_PUT, 32'h0000_0011, 32'h0F0F_0F0F);
    drain();
    // zero capacity acts as one
    set_capacity(5'd0);
    send(FUNC_PUT, 32'h0000_0033, 32'h1111_1111);
    send(FUNC_PUT, 32'h0000_0044, 32'h2222_2222);
    send(FUNC_GET, 32'h0000_0033, 32'h0);
    send(FUNC_GET, 32'h0000_0044, 32'h0);
    drain();
    // oversize capacity saturates
    set_capacity(5'd31);
    send(FUNC_PUT, 32'h0000_0055, 32'h3333_3333);
    send(FUNC_GET, 32'h0000_0044, 32'h0);
    send(FUNC_GET, 32'h0000_0055, 32'h0);
    drain();

    for (p = 0; p < RAND_PHASES; p++) begin
      set_capacity(caps[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct = 10;
          recv_stall_pct = 10;
        end
      endcase
      cap_eff = (caps[p] == 0) ? 1 : ((caps[p] > NUM_SLOTS) ? NUM_SLOTS : int'(caps[p]));
      span = (cap_eff + 4 > POOL_SIZE) ? POOL_SIZE : cap_eff + 4;
      // long receiver hold-off while the sender keeps offering
      if (p == 0) hold_trigger++;
      send_random(PHASE_ITEMS / 2, span);
      drain();
      send_random(PHASE_ITEMS - PHASE_ITEMS / 2, span);
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> lru_key_value_cache_unit.f
rtl/lkv_pkg.sv
rtl/lkv_ram.sv
rtl/lkv_ctrl.sv
rtl/lkv_datapath.sv
rtl/lru_key_value_cache_unit.sv
verif/tb_lru_key_value_cache_unit.sv
